// ===== rtl/core/sm3_pkg.sv =====
// package: sm3 constants, types and round functions
package sm3_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds  = 64;

  localparam logic [31:0] Tj0 = 32'h79CC4519;
  localparam logic [31:0] Tj1 = 32'h7A879D8A;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [255:0] SM3_IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUT,      // write one byte at fill pointer
    CMD_START,    // load working regs and schedule
    CMD_ROUND,    // one compression round
    CMD_FOLD,     // xor into chaining value
    CMD_LEN,      // write length words
    CMD_RESET     // back to initial value
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] put_val;
    logic       count_len;  // message byte, bump bit length
  } ctl_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       full;       // fill wrapped from 63 to 0 on last put
    logic       rnd_last;
  } sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== rtl/core/sm3_if.sv =====
// interfaces: input word and digest word channels
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last_item;
  modport source (output valid, data_word, valid_bytes, last_item, input ready);
  modport sink (input valid, data_word, valid_bytes, last_item, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// ===== rtl/core/sm3_datapath.sv =====
// datapath: block buffer, message schedule, round logic, chaining value
module sm3_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sm3_pkg::ctl_t  ctl_i,
  output sm3_pkg::sts_t  sts_o,
  input  logic [2:0]     out_idx_i,
  output logic [31:0]    digest_o
);
  import sm3_pkg::*;

  logic [31:0] buf_q [BlkWords];
  logic [31:0] w_q [BlkWords];    // sliding schedule window w[j..j+15]
  logic [31:0] v_q [8];
  logic [31:0] r_q [8];
  logic [5:0]  fill_q;
  logic        full_q;
  logic [63:0] bits_q;
  logic [5:0]  rnd_q;

  logic [31:0] wn, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
  logic        hi;

  assign hi  = rnd_q[5] | rnd_q[4];
  assign tj  = hi ? Tj1 : Tj0;
  assign wn  = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  assign a12 = rotl(r_q[0], 5'd12);
  assign ss1 = rotl(a12 + r_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ff  = hi ? ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]))
                  : (r_q[0] ^ r_q[1] ^ r_q[2]);
  assign gg  = hi ? ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]))
                  : (r_q[4] ^ r_q[5] ^ r_q[6]);
  assign tt1 = ff + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
  assign tt2 = gg + r_q[7] + ss1 + w_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      full_q <= 1'b0;
      bits_q <= '0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) v_q[i] <= SM3_IV[255-32*i -: 32];
    end else begin
      case (ctl_i.cmd)
        CMD_PUT: begin
          {full_q, fill_q} <= {1'b0, fill_q} + 7'd1;
          if (ctl_i.count_len) bits_q <= bits_q + 64'd8;
        end
        CMD_START: begin
          rnd_q  <= '0;
          full_q <= 1'b0;
        end
        CMD_ROUND: rnd_q <= rnd_q + 6'd1;
        CMD_FOLD: begin
          for (int i = 0; i < 8; i++) v_q[i] <= v_q[i] ^ r_q[i];
          fill_q <= '0;
        end
        CMD_RESET: begin
          for (int i = 0; i < 8; i++) v_q[i] <= SM3_IV[255-32*i -: 32];
          bits_q <= '0;
          fill_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CMD_PUT: begin
        case (fill_q[1:0])
          2'd0: buf_q[fill_q[5:2]][31:24] <= ctl_i.put_val;
          2'd1: buf_q[fill_q[5:2]][23:16] <= ctl_i.put_val;
          2'd2: buf_q[fill_q[5:2]][15:8]  <= ctl_i.put_val;
          default: buf_q[fill_q[5:2]][7:0] <= ctl_i.put_val;
        endcase
      end
      CMD_LEN: begin
        buf_q[14] <= bits_q[63:32];
        buf_q[15] <= bits_q[31:0];
      end
      CMD_START: begin
        for (int i = 0; i < BlkWords; i++) w_q[i] <= buf_q[i];
        for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
      end
      CMD_ROUND: begin
        for (int i = 0; i < BlkWords - 1; i++) w_q[i] <= w_q[i+1];
        w_q[BlkWords-1] <= wn;
        r_q[0] <= tt1;
        r_q[1] <= r_q[0];
        r_q[2] <= rotl(r_q[1], 5'd9);
        r_q[3] <= r_q[2];
        r_q[4] <= p0(tt2);
        r_q[5] <= r_q[4];
        r_q[6] <= rotl(r_q[5], 5'd19);
        r_q[7] <= r_q[6];
      end
      default: ;
    endcase
  end

  assign sts_o.fill     = fill_q;
  assign sts_o.full     = full_q;
  assign sts_o.rnd_last = (rnd_q == 6'(Rounds - 1));
  assign digest_o       = v_q[out_idx_i];

endmodule

// ===== rtl/core/sm3_ctrl.sv =====
// controller: byte feed, padding, round sequencing and digest output
module sm3_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  sm3_in_if.sink         in_if,
  output sm3_pkg::ctl_t  ctl_o,
  input  sm3_pkg::sts_t  sts_i,
  output logic [2:0]     out_idx_o,
  output logic           out_valid_o,
  output logic           out_last_o,
  input  logic           out_ready_i
);
  import sm3_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FEED, S_CHK, S_START, S_ROUND, S_FOLD,
    S_PAD80, S_PADZ, S_LEN, S_OUT
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] word_q;
  logic [2:0]  cnt_q, cnt_d;
  logic        last_q;
  logic        fin_q, fin_d;     // final block(s) in progress
  logic        lenb_q, lenb_d;   // current block carries length
  logic [2:0]  oidx_q, oidx_d;
  logic [2:0]  nbytes;

  assign nbytes = (in_if.valid_bytes > 3'd4) ? 3'd4 : in_if.valid_bytes;
  assign in_if.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    lenb_d  = lenb_q;
    oidx_d  = oidx_q;
    ctl_o   = '{cmd: CMD_NONE, put_val: 8'h00, count_len: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          cnt_d   = nbytes;
          state_d = S_FEED;
        end
      end
      S_FEED: begin
        if (cnt_q != 3'd0) begin
          ctl_o.cmd = CMD_PUT;
          ctl_o.count_len = 1'b1;
          ctl_o.put_val = word_q[31:24];
          cnt_d   = cnt_q - 3'd1;
          state_d = S_CHK;
        end else if (last_q) begin
          state_d = S_PAD80;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CHK: state_d = sts_i.full ? S_START : S_FEED;
      S_START: begin
        ctl_o.cmd = CMD_START;
        state_d   = S_ROUND;
      end
      S_ROUND: begin
        ctl_o.cmd = CMD_ROUND;
        if (sts_i.rnd_last) state_d = S_FOLD;
      end
      S_FOLD: begin
        ctl_o.cmd = CMD_FOLD;
        if (!fin_q) state_d = S_FEED;
        else if (lenb_q) state_d = S_OUT;
        else state_d = S_PADZ;
      end
      S_PAD80: begin
        ctl_o.cmd     = CMD_PUT;
        ctl_o.put_val = PadByte;
        fin_d   = 1'b1;
        lenb_d  = 1'b0;
        state_d = S_PADZ;
      end
      S_PADZ: begin
        // zero fill to 56, or to block end when length does not fit
        if (!lenb_q && sts_i.fill > 6'd56 || sts_i.full) begin
          if (sts_i.full) state_d = S_START;
          else ctl_o.cmd = CMD_PUT;
        end else if (sts_i.fill < 6'd56) begin
          ctl_o.cmd = CMD_PUT;
        end else begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        ctl_o.cmd = CMD_LEN;
        lenb_d    = 1'b1;
        state_d   = S_START;
      end
      S_OUT: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            ctl_o.cmd = CMD_RESET;
            fin_d   = 1'b0;
            lenb_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      lenb_q  <= 1'b0;
      oidx_q  <= '0;
      last_q  <= 1'b0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      lenb_q  <= lenb_d;
      oidx_q  <= oidx_d;
      if (in_if.valid && in_if.ready) begin
        word_q <= in_if.data_word;
        last_q <= in_if.last_item;
      end else if (ctl_o.cmd == CMD_PUT && state_q == S_FEED) begin
        word_q <= {word_q[23:0], 8'h00};
      end
    end
  end

  assign out_idx_o   = oidx_q;
  assign out_valid_o = (state_q == S_OUT);
  assign out_last_o  = (oidx_q == 3'd7);

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_if.ready) else $error("accept while busy");
  a_out_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (oidx_q == 3'd0)) else $error("digest index not cleared");
  a_round_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START) |=> (state_q == S_ROUND)) else $error("start not followed by round");

endmodule

// ===== rtl/core/sm3_hash_engine_unit.sv =====
// top level: sm3 hash engine, controller plus datapath
//
//  channel  | dir | payload                                | role
//  in_if    | in  | data_word[31:0] valid_bytes[2:0] last  | message words, big-endian
//  out_if   | out | digest_word[31:0] digest_last          | eight digest words per message
//
// a word is accepted in idle, then each valid byte takes a feed and a check state, then an empty feed check
// each full 64-byte block runs start, 64 compression rounds and fold
// the last word adds padding, written one byte at a time, and one or two blocks
// digest words go out one per cycle while out_if ready is high; no input meanwhile
// asynchronous active-low reset loads the initial value and clears counts
module sm3_hash_engine_unit (
  input  logic    clk_i,
  input  logic    rst_ni,
  sm3_in_if.sink  in_if,
  sm3_out_if.source out_if
);
  import sm3_pkg::*;

  ctl_t        ctl;       // controller commands
  sts_t        sts;       // datapath status
  logic [2:0]  out_idx;

  sm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .ctl_o       (ctl),
    .sts_i       (sts),
    .out_idx_o   (out_idx),
    .out_valid_o (out_if.valid),
    .out_last_o  (out_if.digest_last),
    .out_ready_i (out_if.ready)
  );

  // datapath: digest word read straight from chaining value registers
  sm3_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .out_idx_i (out_idx),
    .digest_o  (out_if.digest_word)
  );

endmodule

// ===== sim/sm3_hash_engine_unit_tb.sv =====
// testbench: sm3 hash engine checked against a behavioral hash predictor
module sm3_hash_engine_unit_tb;
  import sm3_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sm3_in_if  in_if ();
  sm3_out_if out_if ();

  sm3_hash_engine_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } digest_t;

  // predictor state
  logic [31:0] chain_q [8];
  logic [31:0] blk_q [16];
  int unsigned fill_cnt;
  logic [63:0] msg_bits;
  digest_t     digest_queue [$];

  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_cycles = 0;

  function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
    logic [63:0] t;
    t = {x, x} << (n % 32);
    return t[63:32];
  endfunction

  task automatic hash_reset();
    logic [255:0] iv;
    iv = 256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;
    for (int k = 0; k < 8; k++) chain_q[k] = iv[255-32*k -: 32];
    for (int k = 0; k < 16; k++) blk_q[k] = '0;
    fill_cnt = 0;
    msg_bits = '0;
  endtask

  task automatic compress();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ffv, ggv, tt1, tt2, x;
    for (int j = 0; j < 16; j++) w[j] = blk_q[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15);
      w[j] = x ^ rol32(x, 15) ^ rol32(x, 23) ^ rol32(w[j-13], 7) ^ w[j-6];
    end
    {a, b, c, d, e, f, g, h} = {chain_q[0], chain_q[1], chain_q[2], chain_q[3],
                                chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
      a12 = rol32(a, 12);
      ss1 = rol32(a12 + e + rol32(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ffv = a ^ b ^ c;
        ggv = e ^ f ^ g;
      end else begin
        ffv = (a & b) | (a & c) | (b & c);
        ggv = (e & f) | (~e & g);
      end
      tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = ggv + h + ss1 + w[j];
      d = c; c = rol32(b, 9); b = a; a = tt1;
      h = g; g = rol32(f, 19); f = e;
      e = tt2 ^ rol32(tt2, 9) ^ rol32(tt2, 17);
    end
    chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
    chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
  endtask

  task automatic store_byte(logic [7:0] v);
    int unsigned pos;
    pos = fill_cnt % 64;
    blk_q[pos/4][31-8*(pos%4) -: 8] = v;
    fill_cnt = pos + 1;
  endtask

  // one accepted input word: absorb bytes, on last pad and queue the digest
  task automatic predict_word(logic [31:0] dw, logic [2:0] nb, logic lst);
    int unsigned cnt;
    digest_t r;
    cnt = (nb > 4) ? 4 : nb;
    for (int i = 0; i < cnt; i++) begin
      store_byte(dw[31-8*i -: 8]);
      msg_bits += 8;
      if (fill_cnt >= 64) begin
        compress();
        fill_cnt = 0;
      end
    end
    if (lst) begin
      store_byte(PadByte);
      if (fill_cnt > 56) begin
        while (fill_cnt < 64) store_byte(8'h00);
        compress();
        fill_cnt = 0;
      end
      while (fill_cnt < 56) store_byte(8'h00);
      blk_q[14] = msg_bits[63:32];
      blk_q[15] = msg_bits[31:0];
      compress();
      for (int k = 0; k < 8; k++) begin
        r.digest_word = chain_q[k];
        r.digest_last = (k == 7);
        digest_queue.push_back(r);
      end
      hash_reset();
    end
  endtask

  // send one word and wait for its handshake
  task automatic send_word(logic [31:0] dw, logic [2:0] nb, logic lst);
    while (snd_idle_pct != 0 && $urandom_range(99, 0) < snd_idle_pct) begin
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_word   <= dw;
    in_if.valid_bytes <= nb;
    in_if.last_item   <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    predict_word(dw, nb, lst);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random message of given length in words, mostly full, with a random tail of zero to four bytes
  task automatic send_message(int unsigned words);
    int unsigned tail;
    tail = $urandom_range(4, 0);
    for (int i = 0; i < words; i++) begin
      // occasionally a short or oversize word mid-message
      if ($urandom_range(19, 0) == 0)
        send_word($urandom, 3'($urandom_range(7, 1)), 1'b0);
      else
        send_word($urandom, 3'd4, 1'b0);
    end
    send_word($urandom, 3'(tail), 1'b1);
  endtask

  // receiver side ready and long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(rcv_idle_pct != 0 && $urandom_range(99, 0) < rcv_idle_pct);
    end
  end

  // digest checker
  always @(posedge clk_i) begin
    digest_t exp_d;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest word %h", out_if.digest_word);
      end else begin
        exp_d = digest_queue.pop_front();
        if (exp_d.digest_word !== out_if.digest_word ||
            exp_d.digest_last !== out_if.digest_last) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: expected %h/%b actual %h/%b", exp_d.digest_word,
                     exp_d.digest_last, out_if.digest_word, out_if.digest_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 900000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drain();
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  // empty message, short and oversize byte counts, known vector "abc", and pad boundary lengths
  task automatic test_directed();
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hFFFFFFFF, 3'd1, 1'b1);
    send_word(32'h00000000, 3'd2, 1'b1);
    send_word(32'hA5A5A5A5, 3'd7, 1'b1);
    send_word(32'h5A5A5A5A, 3'd5, 1'b0);
    send_word(32'h12345678, 3'd6, 1'b1);
    // 55 bytes: pad fits; 56 bytes: second block needed
    for (int i = 0; i < 13; i++) send_word(32'hFFFFFFFF, 3'd4, 1'b0);
    send_word(32'h00FFFF00, 3'd3, 1'b1);
    for (int i = 0; i < 14; i++) send_word(32'h0, 3'd4, 1'b0);
    send_word(32'hDEADBEEF, 3'd0, 1'b1);
  endtask

  task automatic test_random(int unsigned msgs);
    for (int m = 0; m < msgs; m++)
      send_message(($urandom_range(3, 0) == 0) ? $urandom_range(20, 12)
                                                : $urandom_range(6, 0));
  endtask

  // stall the digest side while sending messages
  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int m = 0; m < 4; m++) send_message(2);
  endtask

  initial begin
    in_if.valid       <= 1'b0;
    in_if.data_word   <= '0;
    in_if.valid_bytes <= '0;
    in_if.last_item   <= 1'b0;
    hash_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    snd_idle_pct = 9;  rcv_idle_pct = 88;
    test_random(10);
    snd_idle_pct = 88; rcv_idle_pct = 9;
    test_random(10);
    snd_idle_pct = 0;  rcv_idle_pct = 0;
    test_random(10);
    test_backpressure();
    wait_drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sm3_pkg.sv
rtl/core/sm3_if.sv
rtl/core/sm3_datapath.sv
rtl/core/sm3_ctrl.sv
rtl/core/sm3_hash_engine_unit.sv
sim/sm3_hash_engine_unit_tb.sv
